// ----- hdl/pcfa_pkg.sv -----
// pcfa_pkg: shared constants for the penalty contact force accumulator.
// Operation codes, register indexes, reset values and datapath widths.
// No dependencies.
package pcfa_pkg;

  // operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // configuration register indexes
  localparam logic REG_STIFFNESS = 1'b0;
  localparam logic REG_DAMPING   = 1'b1;

  localparam logic [31:0] STIFFNESS_RESET = 32'd100000;
  localparam logic [23:0] DAMPING_RESET   = 24'd2000;

  localparam int NODE_COUNT_DEFAULT = 1024;

  // field widths
  localparam int NODE_W   = 10;
  localparam int DEPTH_W  = 24;
  localparam int NORM_W   = 16;
  localparam int VEL_W    = 24;
  localparam int TOTAL_W  = 48;
  localparam int STIFF_W  = 32;
  localparam int DAMP_W   = 24;
  localparam int CFG_W    = 32;

  // epoch tag kept next to each accumulator entry
  localparam int EPOCH_W = 8;

endpackage

// ----- hdl/penalty_contact_force_accumulator.sv -----
// penalty_contact_force_accumulator: spring-damper contact force per mesh node,
// accumulated into one synchronous memory. Depends on pcfa_pkg.
// Single module; the accumulator store is an array inside it.

// Each item is one beat on the item channel and gives exactly one result beat.
// An add contact beat forms f = k*depth*n - c*(n.v)*n (k = stiffness, c =
// damping), adds each component to the node's saturating Q32.16 totals and
// reports the new totals; a read beat reports a node's totals; a clear beat
// empties every node and reports node 0 with zero totals. Nodes at or above
// NODE_COUNT, and the unused operation code, change nothing and report zero totals.
// Timing: an item is accepted only while the sequencer is idle, and its result
// is written to the output register by the finish state, which waits while an
// earlier result is stalled; no new item is taken while one is in the sequence.
// The steps follow the multiply chain (k*depth and n*v, then the spring partial
// products and n.v, then (n.v)*n, then the damping partial products, then the
// sums), walked by a sequencer that owns the single accumulator memory from its
// read at accept to its write-back at the end. The result register frees the
// input side: a new item is taken while the previous result still waits.
// Clearing uses an epoch tag stored with each entry, so a clear costs nothing,
// except that after reset and after every 255th clear a clearing pass rewrites
// all tags; no item is accepted during that pass (configuration writes still
// are). Configuration is written through write_enable / reg_index / write_data:
// index 0 is stiffness (32 bit), index 1 damping (low 24 bits of write_data).
module penalty_contact_force_accumulator #(
  parameter int NODE_COUNT = pcfa_pkg::NODE_COUNT_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                write_enable,
  input  logic                                reg_index,
  input  logic [pcfa_pkg::CFG_W-1:0]          write_data,
  // item channel
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic [1:0]                          operation,
  input  logic [pcfa_pkg::NODE_W-1:0]         node_index,
  input  logic [pcfa_pkg::DEPTH_W-1:0]        depth,
  input  logic signed [pcfa_pkg::NORM_W-1:0]  normal_x,
  input  logic signed [pcfa_pkg::NORM_W-1:0]  normal_y,
  input  logic signed [pcfa_pkg::NORM_W-1:0]  normal_z,
  input  logic signed [pcfa_pkg::VEL_W-1:0]   vel_x,
  input  logic signed [pcfa_pkg::VEL_W-1:0]   vel_y,
  input  logic signed [pcfa_pkg::VEL_W-1:0]   vel_z,
  // result channel
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [pcfa_pkg::NODE_W-1:0]         result_node,
  output logic signed [pcfa_pkg::TOTAL_W-1:0] total_x,
  output logic signed [pcfa_pkg::TOTAL_W-1:0] total_y,
  output logic signed [pcfa_pkg::TOTAL_W-1:0] total_z
);

  localparam int ADDR_W  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int EW      = pcfa_pkg::EPOCH_W;
  localparam int TW      = pcfa_pkg::TOTAL_W;
  localparam int S_W     = pcfa_pkg::STIFF_W + pcfa_pkg::DEPTH_W;   // k*depth, 56
  localparam int S_HALF  = S_W / 2;                                 // 28
  localparam int PV_W    = pcfa_pkg::NORM_W + pcfa_pkg::VEL_W;      // n_i*v_i, 40
  localparam int VN_W    = PV_W + 1;                                // |n.v| < 2^40
  localparam int P_W     = VN_W + pcfa_pkg::NORM_W - 1;             // (n.v)*n_i, 56
  localparam int PM_W    = P_W - 1;                                 // |P| < 2^55
  localparam int SP_W    = S_HALF + pcfa_pkg::NORM_W;               // 44
  localparam int SM_W    = SP_W + 15;                               // spring magnitude
  localparam int DH_W    = PM_W;                                    // 31x24 product
  localparam int DL_W    = 2 * pcfa_pkg::DAMP_W;                    // 24x24 product
  localparam int DM_W    = DH_W + 1;
  localparam int SS_W    = SM_W + 1;
  localparam int F_W     = SS_W + 1;
  localparam int SUM_W   = F_W + 1;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_CALC1  = 8'b0000_0010,
    ST_CALC2  = 8'b0000_0100,
    ST_CALC3  = 8'b0000_1000,
    ST_CALC4  = 8'b0001_0000,
    ST_CALC5  = 8'b0010_0000,
    ST_FINISH = 8'b0100_0000,
    ST_SWEEP  = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic [EW-1:0]        tag;
    logic signed [TW-1:0] x;
    logic signed [TW-1:0] y;
    logic signed [TW-1:0] z;
  } acc_word_t;

  state_t state, state_next;

  logic [pcfa_pkg::STIFF_W-1:0] stiffness;
  logic [pcfa_pkg::DAMP_W-1:0]  damping;

  logic [EW-1:0]     epoch;
  logic [ADDR_W-1:0] sweep_cnt;

  // accumulator store
  acc_word_t mem [NODE_COUNT];
  acc_word_t rd_data;
  acc_word_t wr_data;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;

  // captured item
  logic [1:0]                  op_q;
  logic [pcfa_pkg::NODE_W-1:0] node_q;
  logic [ADDR_W-1:0]           addr_q;
  logic                        in_range_q;
  logic signed [pcfa_pkg::NORM_W-1:0] n_q [3];

  // datapath registers
  logic [S_W-1:0]          s_prod;
  logic signed [PV_W-1:0]  pv [3];
  logic signed [VN_W-1:0]  vn;
  logic [SP_W-1:0]         sp_lo [3];
  logic [SP_W-1:0]         sp_hi [3];
  logic signed [TW-1:0]    old_tot [3];
  logic signed [P_W-1:0]   p [3];
  logic [SM_W-1:0]         sm [3];
  logic [DH_W-1:0]         dp_hi [3];
  logic [DL_W-1:0]         dp_lo [3];
  logic                    neg_p [3];
  logic [DM_W-1:0]         dm [3];
  logic signed [SS_W-1:0]  ss [3];
  logic signed [F_W-1:0]   force_q [3];

  // combinational helpers
  logic signed [pcfa_pkg::NORM_W-1:0] n_in [3];
  logic signed [pcfa_pkg::VEL_W-1:0]  v_in [3];
  logic [pcfa_pkg::NORM_W-1:0] nmag [3];
  logic [PM_W-1:0]             pm [3];
  logic signed [SUM_W-1:0]     sum [3];
  logic signed [TW-1:0]        sat [3];

  logic item_accept;
  logic fin_go;
  logic is_add;
  logic is_lookup;
  logic entry_live;
  logic in_range;
  logic [ADDR_W-1:0] rd_addr;

  assign n_in[0] = normal_x;
  assign n_in[1] = normal_y;
  assign n_in[2] = normal_z;
  assign v_in[0] = vel_x;
  assign v_in[1] = vel_y;
  assign v_in[2] = vel_z;

  assign item_stall  = (state != ST_IDLE);
  assign item_accept = item_valid && !item_stall;
  assign fin_go      = (state == ST_FINISH) && (!result_valid || !result_stall);

  assign in_range = (32'(node_index) < NODE_COUNT);
  assign rd_addr  = ADDR_W'(node_index);

  assign is_add     = (op_q == pcfa_pkg::OP_ADD) && in_range_q;
  assign is_lookup  = ((op_q == pcfa_pkg::OP_ADD) || (op_q == pcfa_pkg::OP_READ)) && in_range_q;
  assign entry_live = is_lookup && (rd_data.tag == epoch);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness <= pcfa_pkg::STIFFNESS_RESET;
      damping   <= pcfa_pkg::DAMPING_RESET;
    end else if (write_enable) begin
      case (reg_index)
        pcfa_pkg::REG_STIFFNESS: stiffness <= write_data;
        pcfa_pkg::REG_DAMPING:   damping   <= write_data[pcfa_pkg::DAMP_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (item_accept) state_next = ST_CALC1;
      ST_CALC1:  state_next = ST_CALC2;
      ST_CALC2:  state_next = ST_CALC3;
      ST_CALC3:  state_next = ST_CALC4;
      ST_CALC4:  state_next = ST_CALC5;
      ST_CALC5:  state_next = ST_FINISH;
      ST_FINISH: begin
        if (fin_go) begin
          if (op_q == pcfa_pkg::OP_CLEAR && epoch == {EW{1'b1}}) state_next = ST_SWEEP;
          else state_next = ST_IDLE;
        end
      end
      ST_SWEEP:  if (sweep_cnt == ADDR_W'(NODE_COUNT - 1)) state_next = ST_IDLE;
      default:   state_next = ST_SWEEP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SWEEP;
      sweep_cnt <= '0;
      epoch     <= EW'(1);
    end else begin
      state <= state_next;
      if (state == ST_SWEEP) begin
        sweep_cnt <= (sweep_cnt == ADDR_W'(NODE_COUNT - 1)) ? '0 : sweep_cnt + ADDR_W'(1);
      end
      // a clear moves to a fresh epoch; on wrap the pass resets all tags to 0
      if (fin_go && op_q == pcfa_pkg::OP_CLEAR) begin
        epoch <= (epoch == {EW{1'b1}}) ? EW'(1) : epoch + EW'(1);
      end
    end
  end

  // memory write mux: clearing pass or write-back of an add
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    wr_data   = '0;
    if (state == ST_SWEEP) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_cnt;
    end else if (fin_go && is_add) begin
      mem_we    = 1'b1;
      wr_data.tag = epoch;
      wr_data.x   = sat[0];
      wr_data.y   = sat[1];
      wr_data.z   = sat[2];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= wr_data;
    if (item_accept) rd_data <= mem[rd_addr];
  end

  // combinational pieces of the datapath
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nmag[i] = n_q[i][pcfa_pkg::NORM_W-1] ? pcfa_pkg::NORM_W'(-n_q[i])
                                           : pcfa_pkg::NORM_W'(n_q[i]);
      pm[i]   = p[i][P_W-1] ? PM_W'(-p[i]) : PM_W'(p[i]);
      sum[i]  = SUM_W'(old_tot[i]) + (is_add ? SUM_W'(force_q[i]) : SUM_W'(0));
      if (sum[i][SUM_W-1:TW-1] == '0 || sum[i][SUM_W-1:TW-1] == '1) begin
        sat[i] = sum[i][TW-1:0];
      end else begin
        sat[i] = sum[i][SUM_W-1] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
      end
    end
  end

  // datapath registers, at most one multiply level per step
  always_ff @(posedge clk) begin
    if (item_accept) begin
      op_q       <= operation;
      node_q     <= node_index;
      addr_q     <= rd_addr;
      in_range_q <= in_range;
      s_prod     <= S_W'(stiffness) * S_W'(depth);
      for (int i = 0; i < 3; i++) begin
        n_q[i] <= n_in[i];
        pv[i]  <= PV_W'(n_in[i]) * PV_W'(v_in[i]);
      end
    end
    if (state == ST_CALC1) begin
      vn <= VN_W'(pv[0]) + VN_W'(pv[1]) + VN_W'(pv[2]);
      for (int i = 0; i < 3; i++) begin
        sp_lo[i] <= SP_W'(s_prod[S_HALF-1:0]) * SP_W'(nmag[i]);
        sp_hi[i] <= SP_W'(s_prod[S_W-1:S_HALF]) * SP_W'(nmag[i]);
      end
      old_tot[0] <= entry_live ? rd_data.x : '0;
      old_tot[1] <= entry_live ? rd_data.y : '0;
      old_tot[2] <= entry_live ? rd_data.z : '0;
    end
    if (state == ST_CALC2) begin
      for (int i = 0; i < 3; i++) begin
        p[i]  <= P_W'(vn) * P_W'(n_q[i]);
        // floor(S*|n| / 2^14) with S split at bit 28
        sm[i] <= SM_W'({sp_hi[i], 14'd0}) + SM_W'(sp_lo[i][SP_W-1:14]);
      end
    end
    if (state == ST_CALC3) begin
      for (int i = 0; i < 3; i++) begin
        neg_p[i] <= p[i][P_W-1];
        dp_hi[i] <= DH_W'(pm[i][PM_W-1:24]) * DH_W'(damping);
        dp_lo[i] <= DL_W'(pm[i][23:0]) * DL_W'(damping);
      end
    end
    if (state == ST_CALC4) begin
      for (int i = 0; i < 3; i++) begin
        dm[i] <= DM_W'(dp_hi[i]) + DM_W'(dp_lo[i][DL_W-1:24]);
        ss[i] <= $signed(n_q[i][pcfa_pkg::NORM_W-1] ? (SS_W'(0) - SS_W'(sm[i]))
                                                    : SS_W'(sm[i]));
      end
    end
    if (state == ST_CALC5) begin
      for (int i = 0; i < 3; i++) begin
        force_q[i] <= neg_p[i] ? (F_W'(ss[i]) + $signed(F_W'(dm[i])))
                               : (F_W'(ss[i]) - $signed(F_W'(dm[i])));
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fin_go) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      result_node <= ((op_q == pcfa_pkg::OP_ADD) || (op_q == pcfa_pkg::OP_READ)) ? node_q : '0;
      total_x     <= sat[0];
      total_y     <= sat[1];
      total_z     <= sat[2];
    end
  end

endmodule
